/* rtl/dfsa_pkg.sv */
`default_nettype none

package dfsa_pkg;

   // Slot space and field widths.
   localparam int SLOTS   = 64;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = $clog2(SLOTS + 1);
   localparam int TIME_W  = 32;
   localparam int TYPE_W  = 2;

   // Request codes.
   typedef logic [TYPE_W-1:0] req_code_type;
   localparam req_code_type REQ_CLAIM = 2'd0;
   localparam req_code_type REQ_KEEP  = 2'd1;
   localparam req_code_type REQ_TICK  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request fields, clear the walk
      logic pop;      // claim: pop the free stack and respond
      logic single;   // keep-alive or unused code: respond, recording a keep-alive
      logic issue;    // tick: read the next slot of the walk
      logic finish;   // tick: shift the frame flags and respond
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_last;   // the slot being read is the last one
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/dfsa_ctrl.sv */
`default_nettype none

module dfsa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire dfsa_pkg::req_code_type  req_type,
   input  wire dfsa_pkg::dp_status_type status,
   output dfsa_pkg::dp_cmd_type         cmd,
   output logic                         busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_POP    = 3'd1;
   localparam logic [2:0] S_SINGLE = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_type)
                  dfsa_pkg::REQ_CLAIM: state_in = S_POP;
                  dfsa_pkg::REQ_TICK:  state_in = S_WALK;
                  default:             state_in = S_SINGLE;
               endcase
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_IDLE;
         end
         S_SINGLE: begin
            cmd.single = 1'b1;
            state_in   = S_IDLE;
         end
         S_WALK: begin
            cmd.issue = 1'b1;
            if (status.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last slot read is processed in this cycle.
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* rtl/dfsa_datapath.sv */
`default_nettype none

module dfsa_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dfsa_pkg::dp_cmd_type                cmd,
   input  wire dfsa_pkg::req_code_type              req_type,
   input  wire logic [dfsa_pkg::SLOT_W-1:0]         req_slot,
   input  wire logic [dfsa_pkg::TIME_W-1:0]         req_lifetime,
   input  wire logic [dfsa_pkg::TIME_W-1:0]         req_tick_delta,
   output dfsa_pkg::dp_status_type                  status,
   output logic                                     rsp_valid,
   output logic                                     rsp_granted,
   output logic [dfsa_pkg::SLOT_W-1:0]              rsp_granted_slot,
   output logic [dfsa_pkg::COUNT_W-1:0]             rsp_freed_count,
   output logic [dfsa_pkg::COUNT_W-1:0]             rsp_free_count
);

   localparam int SLOTS   = dfsa_pkg::SLOTS;
   localparam int SLOT_W  = dfsa_pkg::SLOT_W;
   localparam int COUNT_W = dfsa_pkg::COUNT_W;
   localparam int TIME_W  = dfsa_pkg::TIME_W;

   // Captured request fields.
   dfsa_pkg::req_code_type type_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [TIME_W-1:0]      life_ff;
   logic [TIME_W-1:0]      delta_ff;

   // Free stack: memory plus a written flag per entry; an unwritten entry
   // holds its reset value, SLOTS-1 minus its index.
   logic [SLOT_W-1:0]  stack_mem [SLOTS];
   logic [SLOTS-1:0]   stack_valid_ff;
   logic [SLOTS-1:0]   stack_valid_in;
   logic [COUNT_W-1:0] depth_ff;
   logic [COUNT_W-1:0] depth_in;
   logic [SLOT_W-1:0]  top_idx;
   logic [SLOT_W-1:0]  top_q_ff;
   logic               top_valid_ff;
   logic [SLOT_W-1:0]  pop_slot;
   logic               can_pop;
   logic               do_pop;

   // Frame flags and drain state.
   logic [SLOTS-1:0]   now_ff;
   logic [SLOTS-1:0]   now_in;
   logic [SLOTS-1:0]   before_ff;
   logic [SLOTS-1:0]   before_in;
   logic [SLOTS-1:0]   armed_ff;
   logic [SLOTS-1:0]   armed_in;
   logic [TIME_W-1:0]  life_mem [SLOTS];
   logic [TIME_W-1:0]  rem_mem [SLOTS];

   // Walk pipeline: read stage then process stage.
   logic [SLOT_W-1:0]  idx_ff;
   logic [SLOT_W-1:0]  proc_idx_ff;
   logic               proc_valid_ff;
   logic [TIME_W-1:0]  life_q_ff;
   logic [TIME_W-1:0]  rem_q_ff;
   logic [COUNT_W-1:0] freed_ff;

   // Process stage signals.
   logic               arm_new;
   logic               active;
   logic               expire;
   logic [TIME_W-1:0]  rem_eff;
   logic [TIME_W-1:0]  rem_next;
   logic               push_ok;
   logic               do_keep;

   // Response registers.
   logic               rsp_valid_ff;
   logic               granted_ff;
   logic [SLOT_W-1:0]  gslot_ff;
   logic [COUNT_W-1:0] freed_out_ff;
   logic [COUNT_W-1:0] free_count_ff;

   // Capture the request on transfer.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         slot_ff  <= req_slot;
         life_ff  <= req_lifetime;
         delta_ff <= req_tick_delta;
      end
   end

   // Top of stack is read every cycle; the address only moves at edges.
   assign top_idx  = SLOT_W'(depth_ff - COUNT_W'(1));
   assign can_pop  = (depth_ff != '0);
   assign do_pop   = cmd.pop & can_pop;
   assign pop_slot = top_valid_ff ? top_q_ff : SLOT_W'(COUNT_W'(SLOTS) - depth_ff);

   always_ff @(posedge clock) begin
      top_q_ff     <= stack_mem[top_idx];
      top_valid_ff <= stack_valid_ff[top_idx];
   end

   // Slot processing for the tick walk.
   always_comb begin
      arm_new  = before_ff[proc_idx_ff] & ~now_ff[proc_idx_ff];
      active   = arm_new | armed_ff[proc_idx_ff];
      rem_eff  = arm_new ? life_q_ff : rem_q_ff;
      expire   = (rem_eff <= delta_ff);
      rem_next = rem_eff - delta_ff;
      push_ok  = proc_valid_ff & active & expire & (depth_ff != COUNT_W'(SLOTS));
   end

   assign do_keep = cmd.single & (type_ff == dfsa_pkg::REQ_KEEP);

   // Stack depth.
   always_comb begin
      if (do_pop) begin
         depth_in = depth_ff - COUNT_W'(1);
      end else if (push_ok) begin
         depth_in = depth_ff + COUNT_W'(1);
      end else begin
         depth_in = depth_ff;
      end
   end

   // Flag vectors.
   always_comb begin
      stack_valid_in = stack_valid_ff;
      now_in         = now_ff;
      before_in      = before_ff;
      armed_in       = armed_ff;
      if (push_ok) begin
         stack_valid_in[SLOT_W'(depth_ff)] = 1'b1;
      end
      if (proc_valid_ff && active) begin
         armed_in[proc_idx_ff] = ~expire;
      end
      if (do_keep) begin
         now_in[slot_ff] = 1'b1;
      end
      if (cmd.finish) begin
         before_in = now_ff;
         now_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff       <= COUNT_W'(SLOTS);
         stack_valid_ff <= '0;
         now_ff         <= '0;
         before_ff      <= '0;
         armed_ff       <= '0;
      end else begin
         depth_ff       <= depth_in;
         stack_valid_ff <= stack_valid_in;
         now_ff         <= now_in;
         before_ff      <= before_in;
         armed_ff       <= armed_in;
      end
   end

   // Stack memory write on a push.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         stack_mem[SLOT_W'(depth_ff)] <= proc_idx_ff;
      end
   end

   // Lifetime memory: written by keep-alive, read by the walk.
   always_ff @(posedge clock) begin
      if (do_keep) begin
         life_mem[slot_ff] <= life_ff;
      end
      life_q_ff <= life_mem[idx_ff];
   end

   // Remaining-time memory: written by the process stage, read by the walk.
   always_ff @(posedge clock) begin
      if (proc_valid_ff && active && !expire) begin
         rem_mem[proc_idx_ff] <= rem_next;
      end
      rem_q_ff <= rem_mem[idx_ff];
   end

   // Walk counter and pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         proc_valid_ff <= 1'b0;
         freed_ff      <= '0;
      end else begin
         proc_valid_ff <= cmd.issue;
         if (cmd.load) begin
            idx_ff   <= '0;
            freed_ff <= '0;
         end else begin
            if (cmd.issue) begin
               idx_ff <= idx_ff + SLOT_W'(1);
            end
            if (push_ok) begin
               freed_ff <= freed_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= idx_ff;
   end

   assign status.walk_last = (idx_ff == SLOT_W'(SLOTS - 1));

   // Response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.pop | cmd.single | cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      granted_ff    <= do_pop;
      gslot_ff      <= do_pop ? pop_slot : '0;
      freed_out_ff  <= cmd.finish ? freed_ff : '0;
      free_count_ff <= depth_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = granted_ff;
   assign rsp_granted_slot = gslot_ff;
   assign rsp_freed_count  = freed_out_ff;
   assign rsp_free_count   = free_count_ff;

endmodule

`default_nettype wire

/* rtl/deferred_free_slot_allocator_top.sv */
// Deferred-free slot allocator.
// Input channel: a request is transferred at a rising edge where start is
// high and busy is low. req_type selects claim (pop a free slot),
// keep-alive (mark req_slot claimed this frame, record req_lifetime) or
// frame tick (walk all slots, arm and count down drain timers by
// req_tick_delta, return expired slots to the free stack).
// Result channel: every request gives one result, shown for exactly one
// cycle with rsp_valid high; the receiver cannot stall it.
// Sequencing: a claim passes through the pop state and a keep-alive
// through the record state before its result is registered; a tick
// walks the slots, reading one slot per cycle from the timer memories,
// then passes through the drain and finish states. busy stays high until
// the result register is loaded, so a new request may be transferred in
// the cycle the result is shown, but not while one is still in progress.
// Reset: all slots free with slot 0 on top of the stack, all flags and
// timers disarmed; no clearing pass is needed.
`default_nettype none

module deferred_free_slot_allocator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [dfsa_pkg::TYPE_W-1:0]      req_type,
   input  wire logic [dfsa_pkg::SLOT_W-1:0]      req_slot,
   input  wire logic [dfsa_pkg::TIME_W-1:0]      req_lifetime,
   input  wire logic [dfsa_pkg::TIME_W-1:0]      req_tick_delta,
   output logic                                  rsp_valid,
   output logic                                  rsp_granted,
   output logic [dfsa_pkg::SLOT_W-1:0]           rsp_granted_slot,
   output logic [dfsa_pkg::COUNT_W-1:0]          rsp_freed_count,
   output logic [dfsa_pkg::COUNT_W-1:0]          rsp_free_count
);

   dfsa_pkg::dp_cmd_type    cmd;
   dfsa_pkg::dp_status_type status;

   // Sequencing of each request.
   dfsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (dfsa_pkg::req_code_type'(req_type)),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Stack, flags, timer memories and result registers.
   dfsa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (dfsa_pkg::req_code_type'(req_type)),
      .req_slot         (req_slot),
      .req_lifetime     (req_lifetime),
      .req_tick_delta   (req_tick_delta),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_freed_count  (rsp_freed_count),
      .rsp_free_count   (rsp_free_count)
   );

endmodule

`default_nettype wire

/* dv/tb_deferred_free_slot_allocator_top.sv */
`default_nettype none

module tb_deferred_free_slot_allocator_top;

   localparam int SLOTS   = dfsa_pkg::SLOTS;
   localparam int SLOT_W  = dfsa_pkg::SLOT_W;
   localparam int COUNT_W = dfsa_pkg::COUNT_W;
   localparam int TIME_W  = dfsa_pkg::TIME_W;

   localparam dfsa_pkg::req_code_type REQ_CLAIM = dfsa_pkg::REQ_CLAIM;
   localparam dfsa_pkg::req_code_type REQ_KEEP  = dfsa_pkg::REQ_KEEP;
   localparam dfsa_pkg::req_code_type REQ_TICK  = dfsa_pkg::REQ_TICK;

   // Request code that the block must treat as a no-op.
   localparam dfsa_pkg::req_code_type REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS = 235;

   typedef struct packed {
      logic               granted;
      logic [SLOT_W-1:0]  granted_slot;
      logic [COUNT_W-1:0] freed_count;
      logic [COUNT_W-1:0] free_count;
   } alloc_result_type;

   typedef struct packed {
      dfsa_pkg::req_code_type kind;
      logic [SLOT_W-1:0]      slot;
      logic [TIME_W-1:0]      lifetime;
      logic [TIME_W-1:0]      tick_delta;
      logic                   known;
      alloc_result_type       result;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   dfsa_pkg::req_code_type req_type = REQ_CLAIM;
   logic [SLOT_W-1:0]      req_slot = '0;
   logic [TIME_W-1:0]      req_lifetime = '0;
   logic [TIME_W-1:0]      req_tick_delta = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic                   rsp_granted;
   logic [SLOT_W-1:0]      rsp_granted_slot;
   logic [COUNT_W-1:0]     rsp_freed_count;
   logic [COUNT_W-1:0]     rsp_free_count;

   // Side information held alongside the request ports.
   logic                drv_known = 1'b0;
   alloc_result_type    drv_result = '0;

   // Shadow copy of the allocator state.
   logic [SLOT_W-1:0]   shadow_stack [SLOTS];
   int unsigned         shadow_depth;
   bit                  claimed_cur [SLOTS];
   bit                  claimed_prev [SLOTS];
   bit                  timer_armed [SLOTS];
   logic [TIME_W-1:0]   timer_left [SLOTS];
   logic [TIME_W-1:0]   lifetime_rec [SLOTS];

   alloc_result_type    pending_results [$];
   logic [SLOT_W-1:0]   handed_out [$];
   int                  idle_pct = 0;
   int                  errors = 0;
   int                  cycle_count = 0;
   int                  n_claims = 0;
   int                  n_refused = 0;
   int                  n_keeps = 0;
   int                  n_ticks = 0;
   int                  n_unused = 0;
   int                  n_returned = 0;
   int                  n_dropped = 0;
   int                  n_checked = 0;

   // Directed rows; a set known flag means the result is typed in here.
   stim_row_type directed_rows [18] = '{
      '{REQ_CLAIM,  6'd0,  32'd0,        32'd0,        1'b1, '{1'b1, 6'd0, 7'd0, 7'd63}},
      '{REQ_CLAIM,  6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b1, 6'd1, 7'd0, 7'd62}},
      '{REQ_KEEP,   6'd0,  32'd0,        32'hFFFFFFFF, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd62}},
      '{REQ_KEEP,   6'd1,  32'hFFFFFFFF, 32'd0,        1'b1, '{1'b0, 6'd0, 7'd0, 7'd62}},
      '{REQ_KEEP,   6'd63, 32'd0,        32'd0,        1'b1, '{1'b0, 6'd0, 7'd0, 7'd62}},
      '{REQ_TICK,   6'd0,  32'd0,        32'd0,        1'b1, '{1'b0, 6'd0, 7'd0, 7'd62}},
      '{REQ_TICK,   6'd63, 32'hFFFFFFFF, 32'd0,        1'b1, '{1'b0, 6'd0, 7'd2, 7'd64}},
      '{REQ_TICK,   6'd0,  32'd0,        32'hFFFFFFFF, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd64}},
      '{REQ_UNUSED, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd64}},
      '{REQ_CLAIM,  6'd5,  32'd0,        32'd0,        1'b0, '0},
      '{REQ_KEEP,   6'd5,  32'h00030000, 32'd0,        1'b0, '0},
      '{REQ_TICK,   6'd0,  32'd0,        32'd0,        1'b0, '0},
      '{REQ_TICK,   6'd0,  32'd0,        32'h00010000, 1'b0, '0},
      '{REQ_KEEP,   6'd5,  32'h00050000, 32'd0,        1'b0, '0},
      '{REQ_TICK,   6'd0,  32'd0,        32'h00010000, 1'b0, '0},
      '{REQ_TICK,   6'd0,  32'd0,        32'h00008000, 1'b0, '0},
      '{REQ_TICK,   6'd0,  32'd0,        32'h00048000, 1'b0, '0},
      '{REQ_CLAIM,  6'd0,  32'd0,        32'd0,        1'b0, '0}
   };

   deferred_free_slot_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_slot         (req_slot),
      .req_lifetime     (req_lifetime),
      .req_tick_delta   (req_tick_delta),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_freed_count  (rsp_freed_count),
      .rsp_free_count   (rsp_free_count)
   );

   always #1 clock = ~clock;

   // Apply one request to the shadow state and return the result it gives.
   function automatic alloc_result_type predict_allocation(dfsa_pkg::req_code_type kind,
         logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] life, logic [TIME_W-1:0] delta);
      alloc_result_type res;
      res = '0;
      case (kind)
         REQ_CLAIM: begin
            n_claims++;
            if (shadow_depth > 0) begin
               shadow_depth--;
               res.granted = 1'b1;
               res.granted_slot = shadow_stack[shadow_depth];
               handed_out = {handed_out, shadow_stack[shadow_depth]};
               if (handed_out.size() > SLOTS) void'(handed_out.pop_front());
            end else begin
               n_refused++;
            end
         end
         REQ_KEEP: begin
            n_keeps++;
            claimed_cur[slot] = 1'b1;
            lifetime_rec[slot] = life;
         end
         REQ_TICK: begin
            n_ticks++;
            for (int i = 0; i < SLOTS; i++) begin
               if (claimed_prev[i] && !claimed_cur[i]) begin
                  timer_armed[i] = 1'b1;
                  timer_left[i] = lifetime_rec[i];
               end
               if (timer_armed[i]) begin
                  if (timer_left[i] <= delta) begin
                     timer_armed[i] = 1'b0;
                     timer_left[i] = '0;
                     // A return onto a full stack is lost.
                     if (shadow_depth < SLOTS) begin
                        shadow_stack[shadow_depth] = SLOT_W'(i);
                        shadow_depth++;
                        res.freed_count++;
                        n_returned++;
                     end else begin
                        n_dropped++;
                     end
                  end else begin
                     timer_left[i] = timer_left[i] - delta;
                  end
               end
            end
            for (int i = 0; i < SLOTS; i++) begin
               claimed_prev[i] = claimed_cur[i];
               claimed_cur[i] = 1'b0;
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      res.free_count = COUNT_W'(shadow_depth);
      return res;
   endfunction

   // Random lifetimes and deltas: mostly short, with zero, full range and maximum.
   function automatic logic [TIME_W-1:0] random_time(int unsigned short_max);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return '0;
      else if (pick < 22) return $urandom;
      else if (pick < 27) return '1;
      else return $urandom_range(short_max, 0);
   endfunction

   // Mostly claims, keep-alives on handed-out slots and ticks; a little noise.
   function automatic stim_row_type random_row();
      stim_row_type row;
      int unsigned pick;
      pick = $urandom_range(99);
      row = '0;
      row.slot = SLOT_W'($urandom_range(SLOTS - 1));
      row.lifetime = random_time(32'h00060000);
      row.tick_delta = random_time(32'h00030000);
      if (pick < 42) begin
         row.kind = REQ_CLAIM;
      end else if (pick < 80) begin
         row.kind = REQ_KEEP;
         if (handed_out.size() > 0 && $urandom_range(99) < 75)
            row.slot = handed_out[$urandom_range(handed_out.size() - 1)];
      end else if (pick < 95) begin
         row.kind = REQ_TICK;
      end else begin
         row.kind = REQ_UNUSED;
      end
      return row;
   endfunction

   // Present one request, with random idle cycles first, and hold it until transfer.
   task automatic send_request(input stim_row_type row);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= row.kind;
      req_slot <= row.slot;
      req_lifetime <= row.lifetime;
      req_tick_delta <= row.tick_delta;
      drv_known <= row.known;
      drv_result <= row.result;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Check each result against the oldest expectation, then log a new transfer.
   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      alloc_result_type pred;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_granted, rsp_granted_slot, rsp_freed_count, rsp_free_count};
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: result with none expected: granted=%0d slot=%0d freed=%0d free=%0d",
                        $time, got.granted, got.granted_slot, got.freed_count,
                        got.free_count);
            end else begin
               want = pending_results.pop_front();
               n_checked++;
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch expected granted=%0d slot=%0d freed=%0d free=%0d",
                           $time, want.granted, want.granted_slot, want.freed_count,
                           want.free_count);
                  $display("%0t:          actual   granted=%0d slot=%0d freed=%0d free=%0d",
                           $time, got.granted, got.granted_slot, got.freed_count,
                           got.free_count);
               end
            end
         end
         if (start && !busy) begin
            pred = predict_allocation(req_type, req_slot, req_lifetime, req_tick_delta);
            pending_results = {pending_results, (drv_known ? drv_result : pred)};
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("deferred_free_slot_allocator_top verification failed");
         $finish;
      end
   end

   initial begin
      static int pct_by_phase [4] = '{0, 80, 0, 11};
      for (int i = 0; i < SLOTS; i++) begin
         shadow_stack[i] = SLOT_W'(SLOTS - 1 - i);
         claimed_cur[i] = 1'b0;
         claimed_prev[i] = 1'b0;
         timer_armed[i] = 1'b0;
         timer_left[i] = '0;
         lifetime_rec[i] = '0;
      end
      shadow_depth = SLOTS;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at full rate.
      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // Random part in phases of differing sender idling.
      for (int p = 0; p < 4; p++) begin
         idle_pct = pct_by_phase[p];
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_row());
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d claims (%0d refused on an empty stack), %0d keep-alives,",
               n_claims, n_refused, n_keeps);
      $display("%0d ticks returning %0d slots (%0d lost to a full stack), %0d no-ops; %0d checked.",
               n_ticks, n_returned, n_dropped, n_unused, n_checked);
      if (errors == 0) begin
         $display("deferred_free_slot_allocator_top verification clean");
      end else begin
         $display("deferred_free_slot_allocator_top verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
